[hw/rtl/tsen_pkg.sv]
package tsen_pkg;

  // header is four 32-bit words
  localparam int HDR_BYTES = 16;
  localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // detection limits
  localparam logic [31:0] MAGIC_SAME = 32'd100;
  localparam logic [31:0] DETECT_HI  = 32'd1000000;
  localparam logic [31:0] DETECT_LO  = 32'hFFF0BDC0;

  // record type and its swapped prefix
  localparam logic [31:0] TYPE_RECORD  = 32'd30;
  localparam logic [30:0] RECORD_LIMIT = 31'd80;
  localparam logic [31:0] TYPE_STRUCT_LO = 32'd31;
  localparam logic [31:0] TYPE_STRUCT_HI = 32'd35;

  // byte order modes
  localparam logic [1:0] MODE_DETECT  = 2'd0;
  localparam logic [1:0] MODE_SAME    = 2'd1;
  localparam logic [1:0] MODE_SWAPPED = 2'd2;

  // configuration register indexes
  localparam logic REG_BYTE_ORDER = 1'b0;

  // unit width codes
  localparam logic [1:0] UNIT_PASS = 2'd0;
  localparam logic [1:0] UNIT_2    = 2'd1;
  localparam logic [1:0] UNIT_4    = 2'd2;
  localparam logic [1:0] UNIT_8    = 2'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic               is_header;
    logic signed [31:0] tag_kind;
    logic signed [31:0] tag_type;
    logic        [30:0] tag_size;
    logic signed [31:0] tag_next;
    logic        [7:0]  out_byte;
    logic               was_swapped;
    logic               tag_end;
  } out_item_t;

  // one queued command: a header or a group of 1 to 8 data bytes
  typedef struct packed {
    logic            is_header;
    logic [31:0]     tag_kind;
    logic [31:0]     tag_type;
    logic [30:0]     tag_size;
    logic [31:0]     tag_next;
    logic [7:0][7:0] data_bytes;
    logic [2:0]      last_idx;
    logic            swapped;
    logic            tag_end;
  } cmd_t;

  function automatic logic [31:0] rev32(input logic [31:0] v);
    rev32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic detect_swapped(input logic [31:0] raw);
    if (raw == MAGIC_SAME) begin
      detect_swapped = 1'b0;
    end else if (rev32(raw) == MAGIC_SAME) begin
      detect_swapped = 1'b1;
    end else begin
      detect_swapped = (raw > DETECT_HI) && (raw < DETECT_LO);
    end
  endfunction

  function automatic logic [1:0] unit_code(input logic [31:0] t);
    priority if (t == 32'd2 || t == 32'd7 || t == 32'd13 || t == 32'd14 || t == 32'd16) begin
      unit_code = UNIT_2;
    end else if (t == 32'd3 || t == 32'd4 || t == 32'd6 || t == 32'd8) begin
      unit_code = UNIT_4;
    end else if (t == 32'd5 || t == 32'd9 || t == 32'd11) begin
      unit_code = UNIT_8;
    end else if (t >= TYPE_STRUCT_LO && t <= TYPE_STRUCT_HI) begin
      unit_code = UNIT_4;
    end else if (t == TYPE_RECORD) begin
      unit_code = UNIT_4;
    end else begin
      unit_code = UNIT_PASS;
    end
  endfunction

endpackage

[hw/rtl/tsen_front.sv]
module tsen_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsen_pkg::in_item_t in_item,
  output logic              full,
  input  logic [1:0]        byte_order_mode,
  input  logic              q_full,
  output logic              cmd_push,
  output tsen_pkg::cmd_t    cmd
);

  logic         accept;

  // control state
  logic         phase_r, phase_nxt;
  logic         known_r, known_nxt;
  logic         swap_r, swap_nxt;
  logic [3:0]   hcnt_r, hcnt_nxt;
  logic [30:0]  dcnt_r, dcnt_nxt;
  logic [2:0]   fill_r, fill_nxt;

  // payload state
  logic [119:0]    hsh_r, hsh_nxt;
  logic [6:0][7:0] ubuf_r, ubuf_nxt;
  logic [30:0]     size_r, size_nxt;
  logic [30:0]     end_r, end_nxt;
  logic [1:0]      wlog_r, wlog_nxt;

  // values after a file start
  logic         phase_eff, known_eff;
  logic [3:0]   hcnt_eff;
  logic [30:0]  dcnt_eff, d_inc;
  logic [2:0]   fill_eff;

  logic [127:0]    hdr_full;
  logic [3:0][31:0] words;
  logic            swap_h;
  logic [30:0]     size_h, lim, mask;
  logic [1:0]      code_h;
  logic            last;
  logic [7:0]      b;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign b      = in_item.stream_byte;

  assign phase_eff = in_item.file_start ? 1'b0  : phase_r;
  assign known_eff = in_item.file_start ? 1'b0  : known_r;
  assign hcnt_eff  = in_item.file_start ? 4'd0  : hcnt_r;
  assign dcnt_eff  = in_item.file_start ? 31'd0 : dcnt_r;
  assign fill_eff  = in_item.file_start ? 3'd0  : fill_r;
  assign d_inc     = dcnt_eff + 31'd1;
  assign last      = d_inc >= size_r;
  assign hdr_full  = {b, hsh_r};

  // header decode: order, word reversal, size clamp, unit plan
  always_comb begin
    priority if (byte_order_mode == tsen_pkg::MODE_SAME) begin
      swap_h = 1'b0;
    end else if (byte_order_mode == tsen_pkg::MODE_SWAPPED) begin
      swap_h = 1'b1;
    end else if (!known_eff) begin
      swap_h = tsen_pkg::detect_swapped(hdr_full[31:0]);
    end else begin
      swap_h = swap_r;
    end
    for (int j = 0; j < 4; j++) begin
      words[j] = swap_h ? tsen_pkg::rev32(hdr_full[32*j +: 32]) : hdr_full[32*j +: 32];
    end
    size_h = words[2][31] ? 31'd0 : words[2][30:0];
    code_h = swap_h ? tsen_pkg::unit_code(words[1]) : tsen_pkg::UNIT_PASS;
    lim    = size_h;
    if (words[1] == tsen_pkg::TYPE_RECORD && size_h > tsen_pkg::RECORD_LIMIT) begin
      lim = tsen_pkg::RECORD_LIMIT;
    end
    unique case (code_h)
      tsen_pkg::UNIT_2: mask = 31'd1;
      tsen_pkg::UNIT_4: mask = 31'd3;
      tsen_pkg::UNIT_8: mask = 31'd7;
      default:          mask = 31'd0;
    endcase
  end

  // per-item parse
  always_comb begin
    phase_nxt = phase_eff;
    known_nxt = known_eff;
    swap_nxt  = swap_r;
    hcnt_nxt  = hcnt_eff;
    dcnt_nxt  = dcnt_eff;
    fill_nxt  = fill_eff;
    hsh_nxt   = hsh_r;
    ubuf_nxt  = ubuf_r;
    size_nxt  = size_r;
    end_nxt   = end_r;
    wlog_nxt  = wlog_r;
    cmd_push  = 1'b0;
    cmd       = '0;
    if (!phase_eff) begin
      hsh_nxt  = {b, hsh_r[119:8]};
      hcnt_nxt = hcnt_eff + 4'd1;
      if (hcnt_eff == tsen_pkg::HDR_LAST) begin
        hcnt_nxt       = 4'd0;
        swap_nxt       = swap_h;
        known_nxt      = 1'b1;
        size_nxt       = size_h;
        end_nxt        = lim & ~mask;
        wlog_nxt       = code_h;
        dcnt_nxt       = 31'd0;
        fill_nxt       = 3'd0;
        phase_nxt      = size_h != 31'd0;
        cmd_push       = accept;
        cmd.is_header  = 1'b1;
        cmd.tag_kind   = words[0];
        cmd.tag_type   = words[1];
        cmd.tag_size   = size_h;
        cmd.tag_next   = words[3];
        cmd.tag_end    = size_h == 31'd0;
      end
    end else begin
      dcnt_nxt = d_inc;
      if (wlog_r != tsen_pkg::UNIT_PASS && dcnt_eff < end_r) begin
        // the eighth byte of a unit goes straight into the command
        if (fill_eff != 3'd7) begin
          ubuf_nxt[fill_eff] = b;
        end
        fill_nxt = fill_eff + 3'd1;
        cmd.data_bytes[0] = b;
        cmd.swapped       = 1'b1;
        cmd.tag_end       = last;
        unique case (wlog_r)
          tsen_pkg::UNIT_2: begin
            cmd.last_idx      = 3'd1;
            cmd.data_bytes[1] = ubuf_r[0];
          end
          tsen_pkg::UNIT_4: begin
            cmd.last_idx      = 3'd3;
            cmd.data_bytes[1] = ubuf_r[2];
            cmd.data_bytes[2] = ubuf_r[1];
            cmd.data_bytes[3] = ubuf_r[0];
          end
          tsen_pkg::UNIT_8: begin
            cmd.last_idx = 3'd7;
            for (int i = 1; i < 8; i++) begin
              cmd.data_bytes[i] = ubuf_r[7 - i];
            end
          end
          tsen_pkg::UNIT_PASS: begin
            cmd.last_idx = 3'd0;
          end
        endcase
        if (fill_eff == cmd.last_idx) begin
          fill_nxt = 3'd0;
          cmd_push = accept;
        end
      end else begin
        cmd.data_bytes[0] = b;
        cmd.tag_end       = last;
        cmd_push          = accept;
      end
      if (last) begin
        phase_nxt = 1'b0;
        dcnt_nxt  = 31'd0;
        fill_nxt  = 3'd0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      known_r <= 1'b0;
      swap_r  <= 1'b0;
      hcnt_r  <= 4'd0;
      dcnt_r  <= 31'd0;
      fill_r  <= 3'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      known_r <= known_nxt;
      swap_r  <= swap_nxt;
      hcnt_r  <= hcnt_nxt;
      dcnt_r  <= dcnt_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hsh_r  <= hsh_nxt;
      ubuf_r <= ubuf_nxt;
      size_r <= size_nxt;
      end_r  <= end_nxt;
      wlog_r <= wlog_nxt;
    end
  end

endmodule

[hw/rtl/tsen_queue.sv]
module tsen_queue #(
  parameter int DEPTH = tsen_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsen_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output tsen_pkg::cmd_t rdata,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsen_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

[hw/rtl/tsen_back.sv]
module tsen_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  tsen_pkg::cmd_t       head,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output tsen_pkg::out_item_t  out_item
);

  logic                 out_valid_r, out_valid_nxt;
  tsen_pkg::out_item_t  out_item_r, out_item_nxt;
  logic [2:0]           idx_r, idx_nxt;
  logic                 load;

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;
  assign load     = !out_valid_r || pop;

  // walk the head command one result at a time
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_item_nxt = '0;
        if (head.is_header) begin
          out_item_nxt.is_header = 1'b1;
          out_item_nxt.tag_kind  = head.tag_kind;
          out_item_nxt.tag_type  = head.tag_type;
          out_item_nxt.tag_size  = head.tag_size;
          out_item_nxt.tag_next  = head.tag_next;
        end else begin
          out_item_nxt.out_byte    = head.data_bytes[idx_r];
          out_item_nxt.was_swapped = head.swapped;
        end
        out_item_nxt.tag_end = head.tag_end && (idx_r == head.last_idx);
        if (idx_r == head.last_idx) begin
          q_pop   = 1'b1;
          idx_nxt = 3'd0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

[hw/rtl/tag_stream_endian_normalizer_top.sv]
// Tag stream endian normalizer: splits a raw file byte stream into tags
// (16-byte header, then size data bytes) and puts them into host order.
// Input: one byte per item on in_item, taken when push is high and full low;
// file_start marks the first byte of a file and restarts parsing and detection.
// Output: results are read like a queue; out_item holds the oldest one while
// empty is low and it is taken when pop is high. A header gives one result,
// a data byte gives one result, or a whole swapped unit of 2, 4 or 8 bytes
// gives that many results when its last byte arrives.
// Path: a result goes from the taken item into the command queue, then into
// the output register, and from there shows on out_item; a unit's bytes
// follow at one per cycle while pop is high.
// Throughput: one item per cycle in and one result per cycle out; the front
// parser takes a byte every cycle while the command queue has room, and the
// back drains one result per cycle from the queue head while pop is high.
// Stalls: when pop is held low the output register and the queue fill, and
// full rises once the queue is full; nothing is lost.
// Reset: byte order is unknown, parsing expects a header, queue and output
// are empty, byte_order_mode reads 0 (detect).
module tag_stream_endian_normalizer_top #(
  parameter int QUEUE_DEPTH = tsen_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  input  tsen_pkg::in_item_t  in_item,
  output logic                full,
  // result channel
  output logic                empty,
  input  logic                pop,
  output tsen_pkg::out_item_t out_item,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]     mode_r;
  logic           q_full, q_empty, q_push, q_pop;
  tsen_pkg::cmd_t q_wdata, q_rdata;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tsen_pkg::REG_BYTE_ORDER) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tsen_pkg::MODE_DETECT;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == tsen_pkg::REG_BYTE_ORDER) begin
      mode_r <= pwdata[1:0];
    end
  end

  // front parser
  tsen_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_item         (in_item),
    .full            (full),
    .byte_order_mode (mode_r),
    .q_full          (q_full),
    .cmd_push        (q_push),
    .cmd             (q_wdata)
  );

  // command queue
  tsen_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back end result sequencer
  tsen_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

[test/tag_stream_endian_normalizer_top_test.sv]
module tag_stream_endian_normalizer_top_test;
  import tsen_pkg::*;

  // tag data type codes
  localparam logic [31:0] TYPE_VOID     = 32'd0;
  localparam logic [31:0] TYPE_BYTE     = 32'd1;
  localparam logic [31:0] TYPE_SHORT    = 32'd2;
  localparam logic [31:0] TYPE_INT      = 32'd3;
  localparam logic [31:0] TYPE_FLOAT    = 32'd4;
  localparam logic [31:0] TYPE_DOUBLE   = 32'd5;
  localparam logic [31:0] TYPE_JULIAN   = 32'd6;
  localparam logic [31:0] TYPE_USHORT   = 32'd7;
  localparam logic [31:0] TYPE_UINT     = 32'd8;
  localparam logic [31:0] TYPE_ULONG    = 32'd9;
  localparam logic [31:0] TYPE_STRING   = 32'd10;
  localparam logic [31:0] TYPE_LONG     = 32'd11;
  localparam logic [31:0] TYPE_PACK13   = 32'd13;
  localparam logic [31:0] TYPE_PACK14   = 32'd14;
  localparam logic [31:0] TYPE_PACK16   = 32'd16;
  localparam logic [31:0] TYPE_COMPLEX  = 32'd20;
  localparam logic [31:0] TYPE_OLD_PACK = 32'd23;

  // mode value with no name of its own, acts as detect
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0]  CFG_ADDR      = 3'(4 * int'(REG_BYTE_ORDER));
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_AFTER    = 120;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned PHASE_ITEMS   = 38;

  // predicts tag results from accepted bytes and checks the block's output
  class tag_split_checker;
    logic [1:0]  order_mode;
    bit          swap_order;
    bit          order_known;
    bit          in_data;
    logic [3:0]  hdr_cnt;
    logic [31:0] hdr_word [4];
    logic [30:0] data_cnt;
    logic [7:0]  unit_buf [8];
    int unsigned unit_fill;
    out_item_t   pending_results [$];
    int unsigned error_count;

    function new();
      order_mode  = MODE_DETECT;
      swap_order  = 0;
      order_known = 0;
      in_data     = 0;
      hdr_cnt     = '0;
      data_cnt    = '0;
      unit_fill   = 0;
      error_count = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      order_mode = m;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // width of the swap unit at offset offs, and the end of whole units
    function int unsigned unit_bytes(logic [31:0] t, logic [30:0] size, logic [30:0] offs,
                                     output logic [30:0] whole_end);
      int unsigned w;
      logic [30:0] lim;
      w = 1;
      lim = size;
      case (t)
        TYPE_SHORT, TYPE_USHORT, TYPE_PACK13, TYPE_PACK14, TYPE_PACK16: w = 2;
        TYPE_INT, TYPE_FLOAT, TYPE_JULIAN, TYPE_UINT: w = 4;
        TYPE_DOUBLE, TYPE_ULONG, TYPE_LONG: w = 8;
        default: begin
          if (t >= TYPE_STRUCT_LO && t <= TYPE_STRUCT_HI) begin
            w = 4;
          end else if (t == TYPE_RECORD && offs < RECORD_LIMIT) begin
            w = 4;
            if (lim > RECORD_LIMIT) lim = RECORD_LIMIT;
          end
        end
      endcase
      whole_end = lim - 31'(lim % w);
      return w;
    endfunction

    function void push_data(logic [7:0] b, bit moved, bit last);
      out_item_t e;
      e = '0;
      e.out_byte = b;
      e.was_swapped = moved;
      e.tag_end = last;
      pending_results.push_back(e);
    endfunction

    function void take_byte(in_item_t it);
      logic [7:0]  b;
      logic [30:0] size;
      logic [30:0] offs;
      logic [30:0] whole_end;
      logic [31:0] raw;
      int unsigned w;
      bit last;
      out_item_t e;
      b = it.stream_byte;
      // a new file drops the partial tag and rearms detection
      if (it.file_start) begin
        in_data = 0;
        hdr_cnt = '0;
        data_cnt = '0;
        unit_fill = 0;
        order_known = 0;
      end
      if (!in_data) begin
        hdr_word[hdr_cnt[3:2]][8*hdr_cnt[1:0] +: 8] = b;
        if (hdr_cnt != HDR_LAST) begin
          hdr_cnt++;
          return;
        end
        hdr_cnt = '0;
        // byte order: fixed by mode, or detected once per file
        if (order_mode == MODE_SAME) begin
          swap_order = 0;
          order_known = 1;
        end else if (order_mode == MODE_SWAPPED) begin
          swap_order = 1;
          order_known = 1;
        end else if (!order_known) begin
          raw = hdr_word[0];
          if (raw == MAGIC_SAME) swap_order = 0;
          else if (rev32(raw) == MAGIC_SAME) swap_order = 1;
          else swap_order = (raw > DETECT_HI) && (raw < DETECT_LO);
          order_known = 1;
        end
        if (swap_order) begin
          for (int k = 0; k < 4; k++) hdr_word[k] = {<<8{hdr_word[k]}};
        end
        // negative size counts as empty
        if (hdr_word[2][31]) hdr_word[2] = '0;
        data_cnt = '0;
        unit_fill = 0;
        in_data = (hdr_word[2] != 0);
        e = '0;
        e.is_header = 1'b1;
        e.tag_kind = hdr_word[0];
        e.tag_type = hdr_word[1];
        e.tag_size = hdr_word[2][30:0];
        e.tag_next = hdr_word[3];
        e.tag_end = (hdr_word[2] == 0);
        pending_results.push_back(e);
      end else begin
        size = hdr_word[2][30:0];
        offs = data_cnt;
        w = unit_bytes(hdr_word[1], size, offs, whole_end);
        data_cnt = data_cnt + 31'd1;
        last = (data_cnt >= size);
        if (swap_order && w > 1 && offs < whole_end) begin
          // hold the unit back, release it reversed on its last byte
          unit_buf[unit_fill % 8] = b;
          unit_fill++;
          if (unit_fill >= w) begin
            for (int i = 0; i < w; i++) begin
              push_data(unit_buf[(w - 1 - i) % 8], 1'b1, (i == w - 1) ? last : 1'b0);
            end
            unit_fill = 0;
          end
        end else begin
          push_data(b, 1'b0, last);
        end
        if (last) begin
          in_data = 0;
          data_cnt = '0;
          unit_fill = 0;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: %0h", got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("is_header", want.is_header, got.is_header);
      compare_field("tag_kind", want.tag_kind, got.tag_kind);
      compare_field("tag_type", want.tag_type, got.tag_type);
      compare_field("tag_size", want.tag_size, got.tag_size);
      compare_field("tag_next", want.tag_next, got.tag_next);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("was_swapped", want.was_swapped, got.was_swapped);
      compare_field("tag_end", want.tag_end, got.tag_end);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  in_item_t    in_item = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tag_split_checker tags = new();
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  tag_stream_endian_normalizer_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random pop runs, long stalls, one long hold-off to fill the block
  initial begin
    int unsigned run_left;
    int unsigned pop_pct;
    bit held;
    run_left = 0;
    pop_pct = 100;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_sent >= HOLD_AFTER) begin
        held = 1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 2) begin
        pop <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(10, 60);
          case ($urandom_range(0, 2))
            0: pop_pct = 100;
            1: pop_pct = 70;
            default: pop_pct = 30;
          endcase
        end
        run_left--;
        pop <= ($urandom_range(0, 99) < pop_pct);
        @(posedge clk);
        if (pop && !empty) tags.check_result(out_item);
      end
    end
  end

  // offer one byte after a random gap and wait until it is taken
  task automatic send_byte(logic [7:0] b, logic fs);
    in_item_t it;
    int unsigned gap;
    int unsigned r;
    it.stream_byte = b;
    it.file_start = fs;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 12) begin
        gap = $urandom_range(10, 40);
      end else if (r < 45) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = 0;
      end
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    tags.take_byte(it);
    n_sent++;
  endtask

  // header words in file byte order, file_start on the first byte if asked
  task automatic send_header(logic [31:0] kind, logic [31:0] ttype, logic [31:0] size_w,
                             logic [31:0] nxt, bit swapped, bit starting);
    logic [31:0] words [4];
    logic [31:0] raw;
    words = '{kind, ttype, size_w, nxt};
    for (int k = 0; k < 16; k++) begin
      raw = swapped ? rev32(words[k / 4]) : words[k / 4];
      send_byte(raw[8 * (k % 4) +: 8], starting && k == 0);
    end
  endtask

  // one tag with random type and size; a cut tag forces a new file after it
  task automatic send_tag(bit swapped, inout bit fresh);
    logic [31:0] kind;
    logic [31:0] ttype;
    logic [31:0] size_w;
    logic [31:0] nxt;
    int unsigned n;
    int unsigned cut;
    int unsigned r;
    bit starting;
    starting = fresh;
    r = $urandom_range(0, 99);
    if (!starting) begin
      kind = $urandom_range(100, 400);
    end else if (r < 60) begin
      kind = MAGIC_SAME;
    end else begin
      // probe the detection thresholds on the first word of a file
      case (r % 6)
        0: kind = DETECT_HI;
        1: kind = DETECT_HI + 1;
        2: kind = DETECT_LO;
        3: kind = DETECT_LO - 1;
        4: kind = $urandom;
        default: kind = $urandom_range(0, 1000000);
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      ttype = $urandom;
    end else if (r < 20) begin
      ttype = TYPE_STRUCT_LO + $urandom_range(0, 4);
    end else begin
      case ($urandom_range(0, 17))
        0: ttype = TYPE_VOID;
        1: ttype = TYPE_BYTE;
        2: ttype = TYPE_SHORT;
        3: ttype = TYPE_INT;
        4: ttype = TYPE_FLOAT;
        5: ttype = TYPE_DOUBLE;
        6: ttype = TYPE_JULIAN;
        7: ttype = TYPE_USHORT;
        8: ttype = TYPE_UINT;
        9: ttype = TYPE_ULONG;
        10: ttype = TYPE_STRING;
        11: ttype = TYPE_LONG;
        12: ttype = TYPE_PACK13;
        13: ttype = TYPE_PACK14;
        14: ttype = TYPE_PACK16;
        15: ttype = TYPE_COMPLEX;
        16: ttype = TYPE_OLD_PACK;
        default: ttype = TYPE_RECORD;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      size_w = {1'b1, 31'($urandom)};
    end else if (r < 8) begin
      size_w = {1'b0, 31'($urandom)} | 32'h0100_0000;
    end else if (ttype == TYPE_RECORD && r < 50) begin
      size_w = $urandom_range(76, 100);
    end else begin
      size_w = $urandom_range(0, 24);
    end
    nxt = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    n = size_w[31] ? 0 : size_w;
    if (n > 200) begin
      cut = $urandom_range(0, 12);
      fresh = 1;
    end else if (n != 0 && $urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, n - 1);
      fresh = 1;
    end else begin
      cut = n;
      fresh = ($urandom_range(0, 9) == 0);
    end
    send_header(kind, ttype, size_w, nxt, swapped, starting);
    for (int k = 0; k < cut; k++) send_byte(8'($urandom), 1'b0);
  endtask

  // mostly well-formed files with random content, some noise bytes
  task automatic run_phase(int unsigned budget);
    int unsigned start_cnt;
    bit fresh;
    bit swapped;
    start_cnt = n_sent;
    fresh = 1;
    swapped = 0;
    while (n_sent - start_cnt < budget) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        fresh = 1;
      end else begin
        if (fresh) swapped = $urandom_range(0, 1);
        send_tag(swapped, fresh);
      end
    end
  endtask

  // stop offering and wait until every expected result is out
  task automatic settle();
    push <= 1'b0;
    while (tags.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] mode);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR;
    pwdata <= 32'(mode);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tags.set_mode(mode);
  endtask

  initial begin
    logic [1:0] modes [8];
    logic [7:0] dbytes [9];
    modes = '{MODE_SAME, MODE_SWAPPED, MODE_RESERVED, MODE_DETECT,
              MODE_SWAPPED, MODE_SAME, MODE_DETECT, MODE_RESERVED};
    dbytes = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h80};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(MODE_DETECT);

    // swapped file found by its magic kind, one 8-byte unit plus a trailing byte
    send_header(MAGIC_SAME, TYPE_DOUBLE, 32'd9, 32'hFFFF_FFFF, 1'b1, 1'b1);
    foreach (dbytes[k]) send_byte(dbytes[k], 1'b0);

    foreach (modes[p]) begin
      settle();
      cfg_write(modes[p]);
      run_phase(PHASE_ITEMS);
    end
    settle();

    if (tags.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tsen_pkg.sv
hw/rtl/tsen_front.sv
hw/rtl/tsen_queue.sv
hw/rtl/tsen_back.sv
hw/rtl/tag_stream_endian_normalizer_top.sv
test/tag_stream_endian_normalizer_top_test.sv
